>>> src/dtq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types and constants of the deadline timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

    localparam int unsigned DEPTH_DEFAULT = 16;
    localparam int unsigned HANDLE_W = 4;
    localparam int unsigned SLEEP_W = 14;

    // Input item kinds.
    localparam logic [1:0] KIND_ARM = 2'd0;
    localparam logic [1:0] KIND_CANCEL = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Result kinds.
    localparam logic [1:0] RES_ARM_ACK = 2'd0;
    localparam logic [1:0] RES_CANCEL = 2'd1;
    localparam logic [1:0] RES_EXPIRED = 2'd2;
    localparam logic [1:0] RES_SLEEP = 2'd3;

    localparam logic [63:0] NS_PER_MS = 64'd1000000;
    localparam logic [SLEEP_W-1:0] EMPTY_SLEEP_MS = 14'd1000;
    localparam logic [SLEEP_W-1:0] MAX_SLEEP_MS = 14'd10000;
    // Cap threshold: a difference of 10001 ms or more saturates.
    localparam logic [63:0] CAP_NS = 64'd10001000000;
    // Reciprocal of 15625 scaled by 2^42; exact for the 28-bit operand used.
    localparam logic [28:0] MS_RECIP = 29'd281474977;

    typedef struct packed {
        logic [1:0]          kind;
        logic signed [63:0]  deadline;
        logic signed [63:0]  current_time;
        logic [HANDLE_W-1:0] handle;
        logic [31:0]         tag;
        logic                use_channel;
    } in_item_t;

    typedef struct packed {
        logic [1:0]          result_kind;
        logic [HANDLE_W-1:0] slot;
        logic [31:0]         echo_tag;
        logic                echo_channel;
        logic                ok;
        logic                new_earliest;
        logic [SLEEP_W-1:0]  sleep_ms;
        logic                last;
    } out_item_t;

endpackage
`default_nettype wire

>>> src/dtq_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtq_front
// Accepts input items, drops unused kinds and holds a two-entry queue.
// ----------------------------------------------------------------------------
module dtq_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire dtq_pkg::in_item_t s_item,
    input  wire logic             s_valid,
    output logic                  s_ready,
    output dtq_pkg::in_item_t     q_item,
    output logic                  q_valid,
    input  wire logic             q_ready
);

    dtq_pkg::in_item_t buf_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop, useful;

    // Kind three produces nothing and is simply dropped on transfer.
    assign useful = (s_item.kind != dtq_pkg::KIND_UNUSED);
    assign s_ready = (cnt_reg != 2'd2);
    assign push = s_valid && s_ready && useful;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop = q_valid && q_ready;
    assign q_item = buf_reg[rd_ptr_reg];

    // Payload storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= s_item;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop) rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule
`default_nettype wire

>>> src/dtq_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtq_back
// Walks the sorted order list one position a cycle while the output is free to arm and cancel; ticks expire the head.
// ----------------------------------------------------------------------------
module dtq_back #(
    parameter int unsigned DEPTH = dtq_pkg::DEPTH_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire dtq_pkg::in_item_t q_item,
    input  wire logic              q_valid,
    output logic                   q_ready,
    output dtq_pkg::out_item_t     m_item,
    output logic                   m_valid,
    input  wire logic              m_ready
);

    localparam int unsigned IW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ARM = 3'd1;
    localparam logic [2:0] ST_CAN = 3'd2;
    localparam logic [2:0] ST_TICK = 3'd3;
    localparam logic [2:0] ST_DIV = 3'd4;
    localparam logic [2:0] ST_OUT = 3'd5;

    logic [2:0]        state_reg;
    logic [63:0]       dl_mem [DEPTH];
    logic [31:0]       tag_mem [DEPTH];
    logic              ch_mem [DEPTH];
    logic [IW-1:0]     order_reg [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [CW-1:0]     count_reg;
    dtq_pkg::in_item_t cur_reg;
    logic [CW-1:0]     pos_reg;
    logic [IW-1:0]     carry_reg;
    logic              placed_reg;
    logic              found_reg;
    logic [IW-1:0]     new_slot_reg;
    logic              zero_pos_reg;
    logic [27:0]       rem_reg;
    logic [13:0]       ms_reg;
    dtq_pkg::out_item_t out_reg;
    logic              out_valid_reg;

    // Lowest free slot, a priority search over the valid bits.
    logic [IW-1:0] free_slot;
    logic          free_any;
    always_comb begin
        free_slot = '0;
        free_any = 1'b0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_slot = IW'(i);
                free_any = 1'b1;
            end
        end
    end

    // Entry under the walk pointer.
    logic [IW-1:0] pos_idx;
    logic [IW-1:0] pos_slot;
    logic [63:0]   pos_dl;
    logic [63:0]   arm_diff, tick_diff, head_diff;
    logic          arm_after, tick_due;
    assign pos_idx = pos_reg[IW-1:0];
    assign pos_slot = order_reg[pos_idx];
    assign pos_dl = dl_mem[pos_slot];
    assign arm_diff = pos_dl - cur_reg.deadline;
    assign arm_after = (arm_diff != 64'd0) && !arm_diff[63];
    assign tick_diff = cur_reg.current_time - pos_dl;
    assign tick_due = (tick_diff != 64'd0) && !tick_diff[63];
    assign head_diff = pos_dl - cur_reg.current_time;

    // Millisecond quotient: the difference over 64, times the scaled reciprocal.
    logic [56:0] ms_prod;
    assign ms_prod = {29'd0, rem_reg} * {28'd0, dtq_pkg::MS_RECIP};

    logic out_free;
    assign out_free = !out_valid_reg || m_ready;
    assign m_valid = out_valid_reg;
    assign m_item = out_reg;
    assign q_ready = (state_reg == ST_IDLE);

    function automatic dtq_pkg::out_item_t mk(
        input logic [1:0] rk, input logic [3:0] sl, input logic [31:0] tg,
        input logic ch, input logic ok, input logic ne, input logic [13:0] ms,
        input logic lst);
        dtq_pkg::out_item_t r;
        r.result_kind = rk; r.slot = sl; r.echo_tag = tg; r.echo_channel = ch;
        r.ok = ok; r.new_earliest = ne; r.sleep_ms = ms; r.last = lst;
        return r;
    endfunction

    // Sequencer: one order position per cycle while the result register is free, results through one register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (m_ready) out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        cur_reg <= q_item;
                        pos_reg <= '0;
                        placed_reg <= 1'b0;
                        found_reg <= 1'b0;
                        if (q_item.kind == dtq_pkg::KIND_ARM) state_reg <= ST_ARM;
                        else if (q_item.kind == dtq_pkg::KIND_CANCEL)
                            state_reg <= ST_CAN;
                        else state_reg <= ST_TICK;
                    end
                end
                ST_ARM: begin
                    if (out_free) begin
                        if (count_reg >= DEPTH_C || !free_any) begin
                            out_reg <= mk(dtq_pkg::RES_ARM_ACK, '0, '0, 1'b0, 1'b0,
                                          1'b0, '0, 1'b1);
                            out_valid_reg <= 1'b1;
                            state_reg <= ST_IDLE;
                        end else if (pos_reg == count_reg) begin
                            // End of list: store the carried or new slot.
                            order_reg[pos_idx] <= placed_reg ? carry_reg : free_slot;
                            if (!placed_reg) begin
                                zero_pos_reg <= (pos_reg == '0);
                            end
                            valid_reg[free_slot] <= 1'b1;
                            dl_mem[free_slot] <= cur_reg.deadline;
                            tag_mem[free_slot] <= cur_reg.tag;
                            ch_mem[free_slot] <= cur_reg.use_channel;
                            count_reg <= count_reg + 1'b1;
                            out_reg <= mk(dtq_pkg::RES_ARM_ACK, 4'(free_slot), '0,
                                          1'b0, 1'b1,
                                          placed_reg ? zero_pos_reg : (pos_reg == '0),
                                          '0, 1'b1);
                            out_valid_reg <= 1'b1;
                            state_reg <= ST_IDLE;
                        end else begin
                            if (placed_reg) begin
                                order_reg[pos_idx] <= carry_reg;
                                carry_reg <= pos_slot;
                            end else if (arm_after) begin
                                order_reg[pos_idx] <= free_slot;
                                carry_reg <= pos_slot;
                                placed_reg <= 1'b1;
                                zero_pos_reg <= (pos_reg == '0);
                            end
                            pos_reg <= pos_reg + 1'b1;
                        end
                    end
                end
                ST_CAN: begin
                    if (out_free) begin
                        if ({{(32-dtq_pkg::HANDLE_W){1'b0}}, cur_reg.handle} >= DEPTH
                            || !valid_reg[cur_reg.handle[IW-1:0]]) begin
                            out_reg <= mk(dtq_pkg::RES_CANCEL, cur_reg.handle, '0,
                                          1'b0, 1'b0, 1'b0, '0, 1'b1);
                            out_valid_reg <= 1'b1;
                            state_reg <= ST_IDLE;
                        end else if (pos_reg + 1'b1 >= count_reg) begin
                            count_reg <= count_reg - 1'b1;
                            valid_reg[cur_reg.handle[IW-1:0]] <= 1'b0;
                            out_reg <= mk(dtq_pkg::RES_CANCEL, cur_reg.handle, '0,
                                          1'b0, 1'b1, 1'b0, '0, 1'b1);
                            out_valid_reg <= 1'b1;
                            state_reg <= ST_IDLE;
                        end else begin
                            // Once found, close the gap by shifting left.
                            if (found_reg || pos_slot == cur_reg.handle[IW-1:0]) begin
                                found_reg <= 1'b1;
                                order_reg[pos_idx] <= order_reg[pos_idx + 1'b1];
                            end
                            pos_reg <= pos_reg + 1'b1;
                        end
                    end
                end
                ST_TICK: begin
                    // The head always sits at position zero; pop while due.
                    if (out_free) begin
                        if (count_reg != '0 && tick_due) begin
                            out_reg <= mk(dtq_pkg::RES_EXPIRED, 4'(pos_slot),
                                          tag_mem[pos_slot], ch_mem[pos_slot],
                                          1'b0, 1'b0, '0, 1'b0);
                            out_valid_reg <= 1'b1;
                            valid_reg[pos_slot] <= 1'b0;
                            for (int i = 0; i + 1 < DEPTH; i++) begin
                                order_reg[i] <= order_reg[i + 1];
                            end
                            count_reg <= count_reg - 1'b1;
                        end else if (count_reg == '0) begin
                            out_reg <= mk(dtq_pkg::RES_SLEEP, '0, '0, 1'b0, 1'b0,
                                          1'b0, dtq_pkg::EMPTY_SLEEP_MS, 1'b1);
                            out_valid_reg <= 1'b1;
                            state_reg <= ST_IDLE;
                        end else if (head_diff[63] || head_diff < dtq_pkg::NS_PER_MS) begin
                            out_reg <= mk(dtq_pkg::RES_SLEEP, '0, '0, 1'b0, 1'b0,
                                          1'b0, 14'd1, 1'b1);
                            out_valid_reg <= 1'b1;
                            state_reg <= ST_IDLE;
                        end else if (head_diff >= dtq_pkg::CAP_NS) begin
                            out_reg <= mk(dtq_pkg::RES_SLEEP, '0, '0, 1'b0, 1'b0,
                                          1'b0, dtq_pkg::MAX_SLEEP_MS, 1'b1);
                            out_valid_reg <= 1'b1;
                            state_reg <= ST_IDLE;
                        end else begin
                            // Below the cap the difference fits in 34 bits.
                            rem_reg <= head_diff[33:6];
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    // One million is 64 times 15625; the quotient is below 2^14.
                    ms_reg <= ms_prod[55:42];
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        out_reg <= mk(dtq_pkg::RES_SLEEP, '0, '0, 1'b0, 1'b0, 1'b0,
                                      ms_reg, 1'b1);
                        out_valid_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> src/deadline_timer_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deadline_timer_queue
// Sorted queue of pending timers with arm, cancel and tick operations.
// ----------------------------------------------------------------------------
// Channel | Ports                       | Direction
// input   | s_valid, s_ready, s_item    | in
// result  | m_valid, m_ready, m_item    | out
//
// An arm or cancel walks the order list, one position a cycle while the result
// register is free. A tick pops each expired timer from the head, then gives the
// sleep advice, by way of a divide state when the millisecond quotient is needed.
// A two-entry queue sits between front and back. Reset is synchronous and clears
// all timers. Either side may stall freely.
// ----------------------------------------------------------------------------
module deadline_timer_queue #(
    parameter int unsigned DEPTH = dtq_pkg::DEPTH_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire dtq_pkg::in_item_t s_item,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output dtq_pkg::out_item_t     m_item
);

    dtq_pkg::in_item_t q_item;
    logic q_valid, q_ready;

    dtq_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_item(s_item), .s_valid(s_valid),
        .s_ready(s_ready), .q_item(q_item), .q_valid(q_valid), .q_ready(q_ready)
    );

    dtq_back #(.DEPTH(DEPTH)) u_back (
        .aclk(aclk), .aresetn(aresetn), .q_item(q_item), .q_valid(q_valid),
        .q_ready(q_ready), .m_item(m_item), .m_valid(m_valid), .m_ready(m_ready)
    );

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the deadline timer queue against a behavioural queue model: arms,
// cancels and ticks go in through a bursty sender, results are compared
// whole, item by item, as a stalling receiver takes them.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned DEPTH = dtq_pkg::DEPTH_DEFAULT;
    localparam int unsigned LIMIT_CYCLES = 400000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    dtq_pkg::in_item_t  s_item = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    dtq_pkg::out_item_t m_item;

    deadline_timer_queue #(.DEPTH(DEPTH)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

    // Model of the timer store.
    logic [63:0] tq_deadline [DEPTH];
    logic [31:0] tq_tag [DEPTH];
    logic        tq_channel [DEPTH];
    logic        tq_busy [DEPTH];
    int          tq_order [$];

    dtq_pkg::out_item_t expected_results [$];
    int          error_count = 0;
    int          cycle_count = 0;
    bit          stall_hold = 1'b0;
    bit          quiet_rx = 1'b0;
    logic [63:0] near_time = 64'd0;

    // The clock.
    initial begin
        forever #1 aclk = ~aclk;
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic bit is_later(logic [63:0] a, logic [63:0] b);
        logic [63:0] d;
        d = a - b;
        return d != 0 && !d[63];
    endfunction

    function automatic dtq_pkg::out_item_t mk(logic [1:0] rk, int s, logic [31:0] t,
                                              logic c, logic ok, logic ne,
                                              logic [13:0] ms, logic lst);
        dtq_pkg::out_item_t r;
        r.result_kind = rk; r.slot = s[3:0]; r.echo_tag = t; r.echo_channel = c;
        r.ok = ok; r.new_earliest = ne; r.sleep_ms = ms; r.last = lst;
        return r;
    endfunction

    // Work out the results of one transfer and update the model.
    task automatic predict_timer_queue(dtq_pkg::in_item_t it);
        int s, pos;
        logic [63:0] d, ms;
        logic hit;
        s = 0; pos = 0;
        if (it.kind == dtq_pkg::KIND_ARM) begin
            while (s < DEPTH && tq_busy[s]) s++;
            if (s >= DEPTH) begin
                expected_results.push_back(mk(dtq_pkg::RES_ARM_ACK, 0, 0, 0, 0, 0, 0, 1));
            end else begin
                while (pos < tq_order.size() && !is_later(tq_deadline[tq_order[pos]],
                       it.deadline)) pos++;
                tq_order.insert(pos, s);
                tq_busy[s] = 1; tq_deadline[s] = it.deadline;
                tq_tag[s] = it.tag; tq_channel[s] = it.use_channel;
                expected_results.push_back(mk(dtq_pkg::RES_ARM_ACK, s, 0, 0, 1, pos == 0,
                                              0, 1));
            end
        end else if (it.kind == dtq_pkg::KIND_CANCEL) begin
            s = int'(it.handle);
            hit = tq_busy[s];
            if (hit) begin
                foreach (tq_order[i]) if (tq_order[i] == s) pos = i;
                tq_order.delete(pos);
                tq_busy[s] = 0;
            end
            expected_results.push_back(mk(dtq_pkg::RES_CANCEL, s, 0, 0, hit, 0, 0, 1));
        end else if (it.kind == dtq_pkg::KIND_TICK) begin
            while (tq_order.size() > 0 && is_later(it.current_time,
                   tq_deadline[tq_order[0]])) begin
                s = tq_order.pop_front();
                expected_results.push_back(mk(dtq_pkg::RES_EXPIRED, s, tq_tag[s],
                                              tq_channel[s], 0, 0, 0, 0));
                tq_busy[s] = 0;
            end
            if (tq_order.size() == 0) begin
                ms = 64'(dtq_pkg::EMPTY_SLEEP_MS);
            end else begin
                d = tq_deadline[tq_order[0]] - it.current_time;
                if (d[63] || d < dtq_pkg::NS_PER_MS) ms = 1;
                else begin
                    ms = d / dtq_pkg::NS_PER_MS;
                    if (ms > 64'(dtq_pkg::MAX_SLEEP_MS)) ms = 64'(dtq_pkg::MAX_SLEEP_MS);
                end
            end
            expected_results.push_back(mk(dtq_pkg::RES_SLEEP, 0, 0, 0, 0, 0, ms[13:0], 1));
        end
    endtask

    task automatic report_mismatch(string what, dtq_pkg::out_item_t got,
                                   dtq_pkg::out_item_t want);
        error_count++;
        $display("mismatch %s: got %p want %p", what, got, want);
    endtask

    // Send one item, holding valid until the transfer happens.
    task automatic send_item(dtq_pkg::in_item_t it);
        s_item <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_timer_queue(it);
    endtask

    // Drop valid and pause a random number of cycles between bursts.
    int burst_left = 0;
    task automatic pace();
        int g;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 12);
        g = $urandom_range(0, 4);
        if (g != 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    function automatic dtq_pkg::in_item_t arm_item(logic [63:0] dl);
        dtq_pkg::in_item_t it;
        it = '0;
        it.kind = dtq_pkg::KIND_ARM; it.deadline = dl;
        it.tag = $urandom; it.use_channel = 1'($urandom_range(0, 1));
        it.handle = 4'($urandom); it.current_time = {$urandom, $urandom};
        return it;
    endfunction

    function automatic dtq_pkg::in_item_t cancel_item(int h);
        dtq_pkg::in_item_t it;
        it = arm_item({$urandom, $urandom});
        it.kind = dtq_pkg::KIND_CANCEL; it.handle = h[3:0];
        return it;
    endfunction

    function automatic dtq_pkg::in_item_t tick_item(logic [63:0] now);
        dtq_pkg::in_item_t it;
        it = arm_item({$urandom, $urandom});
        it.kind = dtq_pkg::KIND_TICK; it.current_time = now;
        return it;
    endfunction

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    // Result checker and receiver stall pattern.
    always @(posedge aclk) begin
        dtq_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected", m_item, '0);
            end else begin
                want = expected_results.pop_front();
                if (m_item !== want) report_mismatch("result", m_item, want);
            end
        end
        if (stall_hold) m_ready <= 1'b0;
        else if (quiet_rx) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 99) < 70);
    end

    task automatic test_directed();
        dtq_pkg::in_item_t it;
        // Empty tick, cancel of a free slot, unused kind.
        send_item(tick_item(64'd0));
        send_item(cancel_item(3));
        it = tick_item(0); it.kind = dtq_pkg::KIND_UNUSED;
        s_item <= it; s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // Extremes, equal deadlines, far head.
        send_item(arm_item(64'h7FFF_FFFF_FFFF_FFFF));
        send_item(arm_item(64'h8000_0000_0000_0000));
        send_item(arm_item(64'd5000));
        send_item(arm_item(64'd5000));
        send_item(arm_item(64'd50_000_000_000));
        send_item(tick_item(64'd0));
        send_item(tick_item(64'd4_500));
        send_item(cancel_item(2));
        send_item(cancel_item(2));
        // Half-range difference: head exactly 2^63 behind.
        send_item(tick_item(64'd5000 + 64'h8000_0000_0000_0000));
        send_item(tick_item(64'd5001));
        send_item(tick_item(64'hFFFF_FFFF_FFFF_FFFF));
        send_item(tick_item(64'h7FFF_FFFF_FFFF_FFFF));
        send_item(tick_item(64'h8000_0000_0000_0001));
        wait_drained();
    endtask

    // Hold off the receiver while arms back up, then fill the queue and overflow it.
    task automatic test_full_and_backpressure();
        stall_hold = 1'b1;
        fork
            begin
                repeat (300) @(posedge aclk);
                stall_hold = 1'b0;
            end
            begin
                for (int i = 0; i < DEPTH + 2; i++)
                    send_item(arm_item(64'd1_000_000 * $urandom_range(0, 20)));
            end
        join
        wait_drained();
        send_item(tick_item(64'd30_000_000));
        wait_drained();
    endtask

    task automatic test_random();
        int r;
        for (int n = 0; n < 290; n++) begin
            r = $urandom_range(0, 99);
            if (r < 45)
                send_item(arm_item(near_time + $urandom_range(0, 30_000) * 64'd1_000_000
                                   + $urandom_range(0, 999_999)));
            else if (r < 55)
                send_item(arm_item({$urandom, $urandom}));
            else if (r < 70)
                send_item(cancel_item($urandom_range(0, DEPTH - 1)));
            else begin
                near_time = near_time + $urandom_range(0, 8000) * 64'd1_000_000;
                send_item(tick_item(near_time));
            end
            if (n == 150) wait_drained();
            quiet_rx = (n > 200 && n < 240);
            pace();
        end
        quiet_rx = 1'b0;
        wait_drained();
    endtask

    initial begin
        for (int i = 0; i < DEPTH; i++) tq_busy[i] = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_full_and_backpressure();
        test_random();
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

>>> filelist.f
src/dtq_pkg.sv
src/dtq_front.sv
src/dtq_back.sv
src/deadline_timer_queue.sv
tb/sv/tb.sv
